// ===== rtl/pfe_pkg.sv =====
package pfe_pkg;

   localparam int SQ_SIDE    = 5;
   localparam int SQ_LAST    = 4;
   localparam int SQ_CELLS   = 25;
   localparam int ALPHA_SIZE = 26;

   localparam logic [4:0] LETTER_Q = 5'd16;
   localparam logic [4:0] LETTER_Z = 5'd25;

   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_FINISH  = 2'd2;
   localparam logic [1:0] KIND_ENCRYPT = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [1:0] STATUS_MISSING   = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] first_letter;
      logic [4:0] second_letter;
      logic       pad_second;
   } req_type;

   typedef struct packed {
      logic [4:0] cipher_first;
      logic [4:0] cipher_second;
      logic [1:0] status;
   } rsp_type;

   // one letter's place in the square, as decoded by a lane
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
      logic [4:0] down_idx;
      logic [4:0] right_idx;
   } lane_type;

endpackage

// ===== rtl/pfe_ram.sv =====
module pfe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== rtl/pfe_lane.sv =====
module pfe_lane (
   input  logic [4:0]        position,
   output pfe_pkg::lane_type lane
);
   import pfe_pkg::*;

   logic [2:0] row;
   logic [2:0] col;
   logic [4:0] col_full;
   logic [2:0] row_next;
   logic [2:0] col_next;

   // row = position / 5 by threshold compare
   always_comb begin
      priority if (position >= 5'd20) begin
         row = 3'd4;
      end else if (position >= 5'd15) begin
         row = 3'd3;
      end else if (position >= 5'd10) begin
         row = 3'd2;
      end else if (position >= 5'd5) begin
         row = 3'd1;
      end else begin
         row = 3'd0;
      end
   end

   assign col_full = position - 5'(row * SQ_SIDE);
   assign col      = col_full[2:0];
   assign row_next = (row == 3'(SQ_LAST)) ? 3'd0 : row + 3'd1;
   assign col_next = (col == 3'(SQ_LAST)) ? 3'd0 : col + 3'd1;

   assign lane.row       = row;
   assign lane.col       = col;
   assign lane.down_idx  = 5'(row_next * SQ_SIDE) + 5'(col);
   assign lane.right_idx = 5'(row * SQ_SIDE) + 5'(col_next);

endmodule

// ===== rtl/pfe_merge.sv =====
module pfe_merge (
   input  pfe_pkg::lane_type lane_a,
   input  pfe_pkg::lane_type lane_b,
   output logic [4:0]        cell_idx_a,
   output logic [4:0]        cell_idx_b
);
   import pfe_pkg::*;

   logic same_col;
   logic same_row;

   assign same_col = (lane_a.col == lane_b.col);
   assign same_row = (lane_a.row == lane_b.row);

   // equal letters share a column, so column rule wins
   always_comb begin
      priority if (same_col) begin
         cell_idx_a = lane_a.down_idx;
         cell_idx_b = lane_b.down_idx;
      end else if (same_row) begin
         cell_idx_a = lane_a.right_idx;
         cell_idx_b = lane_b.right_idx;
      end else begin
         cell_idx_a = 5'(lane_a.row * SQ_SIDE) + 5'(lane_b.col);
         cell_idx_b = 5'(lane_b.row * SQ_SIDE) + 5'(lane_a.col);
      end
   end

endmodule

// ===== rtl/playfair_digraph_encryptor_unit.sv =====
// Playfair square builder and pair encryptor.
// Input channel: a word on req_data is taken at a rising edge with start high
// and busy low. Kinds: clear square, key letter, finish key, encrypt pair.
// Result channel: rsp_strobe is high for one cycle with rsp_data; only an
// encrypt word makes a result. The receiver cannot stall, so results are
// never held back or dropped.
// Sequencing per kind:
//   clear, key letter: take effect at the accept edge, busy stays low.
//   finish key: the fill walk visits one letter per cycle; ignored once ready.
//   encrypt: position RAM read, then square RAM read, then the result
//   register; the next word is taken in the strobe cycle, so no new encrypt
//   is taken before the last result. The two RAM reads in series set this pace.
// Two lanes decode each letter's position into row, column and shifted
// cell indices; a merge stage picks column, row or rectangle rule.
// Reset (synchronous): square empty and not ready, no result pending.
// Cell and position RAMs are not cleared; unwritten entries may be read,
// but only for results with an error status, whose letters are zero.
module playfair_digraph_encryptor_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pfe_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pfe_pkg::rsp_type rsp_data
);
   import pfe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOOK = 4'b0010,
      ST_CELL = 4'b0100,
      ST_FILL = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [ALPHA_SIZE-1:0] present_ff, present_in;
   logic [4:0]           fill_ff, fill_in;
   logic                 ready_ff, ready_in;
   logic [4:0]           walk_ff, walk_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [4:0] letter_a;
   logic [4:0] letter_b;
   logic       ok_a;
   logic       ok_b;
   logic [4:0] pos_addr_a;
   logic [4:0] pos_addr_b;
   logic [4:0] pos_a;
   logic [4:0] pos_b;
   logic [4:0] cell_idx_a;
   logic [4:0] cell_idx_b;
   logic [4:0] cell_a;
   logic [4:0] cell_b;
   logic       place_en;
   logic [4:0] place_letter;
   logic       place_ok;
   lane_type   lane_a;
   lane_type   lane_b;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // pad replaces second letter with z
   assign letter_a = req_data.first_letter;
   assign letter_b = req_data.pad_second ? LETTER_Z : req_data.second_letter;
   assign ok_a     = (letter_a < 5'(ALPHA_SIZE)) && present_ff[letter_a];
   assign ok_b     = (letter_b < 5'(ALPHA_SIZE)) && present_ff[letter_b];

   // keep position reads inside the RAM for letters that fail anyway
   assign pos_addr_a = (letter_a < 5'(ALPHA_SIZE)) ? letter_a : 5'd0;
   assign pos_addr_b = (letter_b < 5'(ALPHA_SIZE)) ? letter_b : 5'd0;

   // shared place logic: key words from input, fill walk from counter
   assign place_letter = (state_ff == ST_FILL) ? walk_ff : req_data.first_letter;
   assign place_ok     = (place_letter < 5'(ALPHA_SIZE)) && (place_letter != LETTER_Q)
                         && !present_ff[place_letter] && (fill_ff < 5'(SQ_CELLS));
   assign place_en     = place_ok && !ready_ff
                         && ((state_ff == ST_FILL)
                             || (accept && (req_data.kind == KIND_KEY)));

   always_comb begin
      state_in      = state_ff;
      present_in    = present_ff;
      fill_in       = fill_ff;
      ready_in      = ready_ff;
      walk_in       = walk_ff;
      status_in     = status_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      if (place_en) begin
         present_in[place_letter] = 1'b1;
         fill_in                  = fill_ff + 5'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_CLEAR: begin
                     present_in = '0;
                     fill_in    = 5'd0;
                     ready_in   = 1'b0;
                  end
                  KIND_KEY: begin
                  end
                  KIND_FINISH: begin
                     if (!ready_ff) begin
                        walk_in  = 5'd0;
                        state_in = ST_FILL;
                     end
                  end
                  KIND_ENCRYPT: begin
                     priority if (!ready_ff) begin
                        status_in = STATUS_NOT_READY;
                     end else if (!ok_a || !ok_b) begin
                        status_in = STATUS_MISSING;
                     end else begin
                        status_in = STATUS_OK;
                     end
                     state_in = ST_LOOK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            state_in = ST_CELL;
         end
         ST_CELL: begin
            rsp_strobe_in = 1'b1;
            if (status_ff == STATUS_OK) begin
               rsp_data_in.cipher_first  = cell_a;
               rsp_data_in.cipher_second = cell_b;
            end else begin
               rsp_data_in.cipher_first  = 5'd0;
               rsp_data_in.cipher_second = 5'd0;
            end
            rsp_data_in.status = status_ff;
            state_in           = ST_IDLE;
         end
         ST_FILL: begin
            walk_in = walk_ff + 5'd1;
            if (walk_ff == 5'(ALPHA_SIZE - 1)) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         present_ff    <= '0;
         fill_ff       <= 5'd0;
         ready_ff      <= 1'b0;
         walk_ff       <= 5'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         present_ff    <= present_in;
         fill_ff       <= fill_in;
         ready_ff      <= ready_in;
         walk_ff       <= walk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // letter -> cell index
   pfe_ram #(
      .WIDTH(5),
      .DEPTH(ALPHA_SIZE)
   ) u_pos_ram (
      .clock    (clock),
      .wr_en    (place_en),
      .wr_addr  (place_letter),
      .wr_data  (fill_ff),
      .rd_addr_a(pos_addr_a),
      .rd_addr_b(pos_addr_b),
      .rd_data_a(pos_a),
      .rd_data_b(pos_b)
   );

   pfe_lane u_lane_a (
      .position(pos_a),
      .lane    (lane_a)
   );

   pfe_lane u_lane_b (
      .position(pos_b),
      .lane    (lane_b)
   );

   pfe_merge u_merge (
      .lane_a    (lane_a),
      .lane_b    (lane_b),
      .cell_idx_a(cell_idx_a),
      .cell_idx_b(cell_idx_b)
   );

   // cell index -> letter, row-major
   pfe_ram #(
      .WIDTH(5),
      .DEPTH(SQ_CELLS)
   ) u_cell_ram (
      .clock    (clock),
      .wr_en    (place_en),
      .wr_addr  (fill_ff),
      .wr_data  (place_letter),
      .rd_addr_a(cell_idx_a),
      .rd_addr_b(cell_idx_b),
      .rd_data_a(cell_a),
      .rd_data_b(cell_b)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // result only follows the square read cycle
   a_strobe_after_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_CELL))
      else $error("result strobe without square read");

   // each placed letter bumps the fill count exactly once
   a_present_matches_fill: assert property (@(posedge clock) disable iff (reset)
      5'($countones(present_ff)) == fill_ff)
      else $error("present bits and fill count disagree");

   // a finished square holds all 25 letters
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (fill_ff == 5'(SQ_CELLS)))
      else $error("square ready but not full");

   // error results carry zero letters
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_data_ff.status != STATUS_OK))
      |-> ((rsp_data_ff.cipher_first == 5'd0) && (rsp_data_ff.cipher_second == 5'd0)))
      else $error("error result with nonzero letters");

endmodule
